@@ hdl/i2cbb_pkg.sv @@
`default_nettype none
package i2cbb_pkg;

	localparam int PHASE_W = 16;
	localparam int TIMEOUT_W = 10;
	localparam int SEQ_W = 5;
	localparam int ACT_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd100;
	localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 10'd300;

	localparam logic CFG_PHASE_TICKS = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	localparam logic [ACT_W-1:0] ACT_START = 3'd0;
	localparam logic [ACT_W-1:0] ACT_STOP = 3'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_WAIT = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ = 3'd4;
	localparam logic [ACT_W-1:0] ACT_ACK = 3'd5;
	localparam logic [ACT_W-1:0] ACT_NACK = 3'd6;

	localparam logic [SEQ_W-1:0] SEQ_IDLE = 5'd0;
	localparam logic [SEQ_W-1:0] SEQ_FIRST = 5'd1;
	localparam logic [SEQ_W-1:0] SEQ_POLL = 5'd3;

	localparam logic [1:0] MOD3_LUT [32] = '{
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
		2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
		2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
	};

	typedef struct packed {
		logic cmd_valid;
		logic [ACT_W-1:0] action;
		logic [7:0] write_data;
		logic sda_in;
	} item_t;

	typedef struct packed {
		logic scl_out;
		logic sda_out;
		logic busy_res;
		logic done_res;
		logic [7:0] read_data;
		logic ack_missing;
	} result_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_ticks;
		logic [TIMEOUT_W-1:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic scl;
		logic sda;
	} lines_t;

	function automatic logic [SEQ_W-1:0] phases_of(input logic [ACT_W-1:0] act);
		logic [SEQ_W-1:0] n;
		case (act)
			ACT_WRITE: n = 5'd24;
			ACT_WAIT: n = 5'd2;
			ACT_READ: n = 5'd19;
			default: n = 5'd3;
		endcase
		return n;
	endfunction

	function automatic lines_t levels_of(input logic [ACT_W-1:0] act,
			input logic [SEQ_W-1:0] k, input logic msb);
		lines_t l;
		case (act)
			ACT_START: begin
				l.scl = (k < 5'd2);
				l.sda = (k == 5'd0);
			end
			ACT_STOP: begin
				l.scl = (k >= 5'd1);
				l.sda = (k == 5'd2);
			end
			ACT_WRITE: begin
				l.scl = (MOD3_LUT[k] == 2'd1);
				l.sda = msb;
			end
			ACT_WAIT: begin
				l.scl = (k >= 5'd1);
				l.sda = 1'b1;
			end
			ACT_READ: begin
				l.scl = (k < 5'd16) ? k[0] : (k == 5'd17);
				l.sda = 1'b1;
			end
			ACT_ACK: begin
				l.scl = (k == 5'd1);
				l.sda = 1'b0;
			end
			default: begin
				l.scl = (k == 5'd1);
				l.sda = 1'b1;
			end
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

@@ hdl/i2cbb_cfg.sv @@
`default_nettype none
module i2cbb_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [i2cbb_pkg::CFG_DATA_W-1:0] cfg_data,
	output i2cbb_pkg::cfg_t cfg
);
	import i2cbb_pkg::*;

	logic [PHASE_W-1:0] phase_ticks_q;
	logic [TIMEOUT_W-1:0] ack_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_TICKS: phase_ticks_q <= cfg_data[PHASE_W-1:0];
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.phase_ticks = phase_ticks_q;
	assign cfg.ack_timeout = ack_timeout_q;
endmodule
`default_nettype wire

@@ hdl/i2cbb_core.sv @@
`default_nettype none
module i2cbb_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire i2cbb_pkg::item_t item,
	input wire i2cbb_pkg::cfg_t cfg,
	output i2cbb_pkg::result_t res
);
	import i2cbb_pkg::*;

	logic [SEQ_W-1:0] seq_q, seq_n;
	logic [ACT_W-1:0] act_q, act_n;
	logic [7:0] shift_q, shift_n;
	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [TIMEOUT_W-1:0] ackw_q, ackw_n;
	logic scl_q, scl_n;
	logic sda_q, sda_n;
	logic err_q, err_n;
	logic [7:0] rbyte_q, rbyte_n;
	logic done;
	logic [SEQ_W-1:0] k;
	lines_t lv;

	assign k = seq_q - 5'd1;

	always_comb begin
		seq_n = seq_q;
		act_n = act_q;
		shift_n = shift_q;
		phase_n = phase_q;
		ackw_n = ackw_q;
		scl_n = scl_q;
		sda_n = sda_q;
		err_n = err_q;
		rbyte_n = rbyte_q;
		done = 1'b0;
		lv = '0;
		if (seq_q == SEQ_IDLE) begin
			if (item.cmd_valid && item.action <= ACT_NACK) begin
				act_n = item.action;
				if (item.action == ACT_WRITE)
					shift_n = item.write_data;
				else if (item.action == ACT_READ)
					shift_n = '0;
				if (item.action == ACT_WAIT) begin
					err_n = 1'b0;
					ackw_n = '0;
				end
				seq_n = SEQ_FIRST;
				phase_n = 16'd1;
				lv = levels_of(item.action, 5'd0, shift_n[7]);
				scl_n = lv.scl;
				sda_n = lv.sda;
			end
		end else if (act_q == ACT_WAIT && seq_q == SEQ_POLL) begin
			if (!item.sda_in) begin
				scl_n = 1'b0;
				seq_n = SEQ_IDLE;
				done = 1'b1;
			end else if (ackw_q >= cfg.ack_timeout) begin
				err_n = 1'b1;
				act_n = ACT_STOP;
				seq_n = SEQ_FIRST;
				phase_n = 16'd1;
				lv = levels_of(ACT_STOP, 5'd0, shift_q[7]);
				scl_n = lv.scl;
				sda_n = lv.sda;
			end else begin
				ackw_n = ackw_q + 10'd1;
			end
		end else if (phase_q < cfg.phase_ticks) begin
			phase_n = phase_q + 16'd1;
		end else begin
			if (act_q == ACT_WRITE && MOD3_LUT[k] == 2'd2)
				shift_n = {shift_q[6:0], 1'b0};
			else if (act_q == ACT_READ && k < 5'd16 && k[0])
				shift_n = {shift_q[6:0], item.sda_in};
			if (act_q == ACT_READ && k == 5'd18)
				rbyte_n = shift_q;
			if ({1'b0, k} + 6'd1 >= {1'b0, phases_of(act_q)}) begin
				if (act_q == ACT_WAIT) begin
					seq_n = SEQ_POLL;
					phase_n = '0;
					scl_n = 1'b1;
					sda_n = 1'b1;
				end else begin
					seq_n = SEQ_IDLE;
					done = 1'b1;
				end
			end else begin
				seq_n = seq_q + 5'd1;
				phase_n = 16'd1;
				lv = levels_of(act_q, seq_q, shift_n[7]);
				scl_n = lv.scl;
				sda_n = lv.sda;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
			act_q <= ACT_START;
			shift_q <= '0;
			phase_q <= '0;
			ackw_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			err_q <= 1'b0;
			rbyte_q <= '0;
		end else if (step) begin
			seq_q <= seq_n;
			act_q <= act_n;
			shift_q <= shift_n;
			phase_q <= phase_n;
			ackw_q <= ackw_n;
			scl_q <= scl_n;
			sda_q <= sda_n;
			err_q <= err_n;
			rbyte_q <= rbyte_n;
		end
	end

	assign res.scl_out = scl_n;
	assign res.sda_out = sda_n;
	assign res.busy_res = (seq_n != SEQ_IDLE);
	assign res.done_res = done;
	assign res.read_data = rbyte_n;
	assign res.ack_missing = err_n;
endmodule
`default_nettype wire

@@ hdl/i2c_bitbang_master.sv @@
// channel   handshake                 word
// in        in_valid / in_stall       cmd_valid, action, write_data, sda_in
// out       out_valid / out_stall     scl_out, sda_out, busy_res, done_res,
//                                     read_data, ack_missing
// cfg       cfg_we                    cfg_index, cfg_data
//
// One word in, one word out; a word enters every cycle unless in_stall holds it,
// passing the input register, then the sequencer step into the output register.
// The sequencer state advances only when the input register moves a word on.
// A stalled output holds its word; the input stalls only while both
// registers are full. arst_n clears state: idle, lines released, timing 100/300.
`default_nettype none
module i2c_bitbang_master (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd_valid,
	input wire logic [2:0] action,
	input wire logic [7:0] write_data,
	input wire logic sda_in,
	output logic out_valid,
	input wire logic out_stall,
	output logic scl_out,
	output logic sda_out,
	output logic busy_res,
	output logic done_res,
	output logic [7:0] read_data,
	output logic ack_missing,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [i2cbb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import i2cbb_pkg::*;

	item_t item_s1;
	logic valid_s1;
	result_t res_s2;
	logic valid_s2;
	result_t res;
	cfg_t cfg;
	logic out_ready;
	logic step;
	logic in_take;

	assign out_ready = !valid_s2 || !out_stall;
	assign step = valid_s1 && out_ready;
	assign in_stall = valid_s1 && !out_ready;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd_valid <= cmd_valid;
			item_s1.action <= action;
			item_s1.write_data <= write_data;
			item_s1.sda_in <= sda_in;
		end
	end

	i2cbb_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	i2cbb_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.cfg(cfg),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign scl_out = res_s2.scl_out;
	assign sda_out = res_s2.sda_out;
	assign busy_res = res_s2.busy_res;
	assign done_res = res_s2.done_res;
	assign read_data = res_s2.read_data;
	assign ack_missing = res_s2.ack_missing;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("done and busy together");

	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stall without a full pipe");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("stepped word missing at output");
endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
	import i2cbb_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic cmd_valid;
	logic [2:0] action;
	logic [7:0] write_data;
	logic sda_in;
	logic out_valid;
	logic out_stall;
	logic scl_out;
	logic sda_out;
	logic busy_res;
	logic done_res;
	logic [7:0] read_data;
	logic ack_missing;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	i2c_bitbang_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd_valid(cmd_valid),
		.action(action),
		.write_data(write_data),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_data(read_data),
		.ack_missing(ack_missing),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// sequencer mirror
	logic [PHASE_W-1:0] phase_cfg;
	logic [TIMEOUT_W-1:0] timeout_cfg;
	logic [SEQ_W-1:0] seq_ph;
	logic [ACT_W-1:0] cur_act;
	logic [7:0] shifter;
	logic [PHASE_W-1:0] dwell;
	logic [TIMEOUT_W-1:0] poll_count;
	logic scl_q;
	logic sda_q;
	logic nak_flag;
	logic [7:0] rd_byte;

	result_t pending_results[$];
	int mismatch_count;
	int quiet_cycles;
	bit idle_on;
	bit hold_req;
	bit never_ack;

	function automatic int phases_in(input logic [ACT_W-1:0] act);
		case (act)
			ACT_WRITE: return 24;
			ACT_WAIT: return 2;
			ACT_READ: return 19;
			default: return 3;
		endcase
	endfunction

	function automatic void drive_phase();
		logic [SEQ_W-1:0] k;
		k = seq_ph - 5'd1;
		case (cur_act)
			ACT_START: begin
				scl_q = (k < 5'd2);
				sda_q = (k == 5'd0);
			end
			ACT_STOP: begin
				scl_q = (k >= 5'd1);
				sda_q = (k == 5'd2);
			end
			ACT_WRITE: begin
				scl_q = ((k % 3) == 1);
				sda_q = shifter[7];
			end
			ACT_WAIT: begin
				scl_q = (k >= 5'd1);
				sda_q = 1'b1;
			end
			ACT_READ: begin
				scl_q = (k < 5'd16) ? k[0] : (k == 5'd17);
				sda_q = 1'b1;
			end
			ACT_ACK: begin
				scl_q = (k == 5'd1);
				sda_q = 1'b0;
			end
			default: begin
				scl_q = (k == 5'd1);
				sda_q = 1'b1;
			end
		endcase
	endfunction

	function automatic void begin_command();
		seq_ph = SEQ_FIRST;
		dwell = 16'd1;
		drive_phase();
	endfunction

	function automatic result_t tick_sequencer(input item_t w);
		logic [SEQ_W-1:0] k;
		logic fin;
		result_t r;
		fin = 1'b0;
		if (seq_ph == SEQ_IDLE) begin
			if (w.cmd_valid && w.action <= ACT_NACK) begin
				cur_act = w.action;
				if (w.action == ACT_WRITE)
					shifter = w.write_data;
				else if (w.action == ACT_READ)
					shifter = 8'd0;
				if (w.action == ACT_WAIT) begin
					nak_flag = 1'b0;
					poll_count = '0;
				end
				begin_command();
			end
		end else if (cur_act == ACT_WAIT && seq_ph == SEQ_POLL) begin
			if (!w.sda_in) begin
				scl_q = 1'b0;
				seq_ph = SEQ_IDLE;
				fin = 1'b1;
			end else if (poll_count >= timeout_cfg) begin
				nak_flag = 1'b1;
				cur_act = ACT_STOP;
				begin_command();
			end else begin
				poll_count = poll_count + 1'b1;
			end
		end else if (dwell < phase_cfg) begin
			dwell = dwell + 1'b1;
		end else begin
			k = seq_ph - 5'd1;
			if (cur_act == ACT_WRITE && (k % 3) == 2)
				shifter = shifter << 1;
			else if (cur_act == ACT_READ && k < 5'd16 && k[0])
				shifter = {shifter[6:0], w.sda_in};
			if (cur_act == ACT_READ && k == 5'd18)
				rd_byte = shifter;
			if (int'(k) + 1 >= phases_in(cur_act)) begin
				if (cur_act == ACT_WAIT) begin
					seq_ph = SEQ_POLL;
					dwell = '0;
					scl_q = 1'b1;
					sda_q = 1'b1;
				end else begin
					seq_ph = SEQ_IDLE;
					fin = 1'b1;
				end
			end else begin
				seq_ph = k + 5'd2;
				dwell = 16'd1;
				drive_phase();
			end
		end
		r.scl_out = scl_q;
		r.sda_out = sda_q;
		r.busy_res = (seq_ph != SEQ_IDLE);
		r.done_res = fin;
		r.read_data = rd_byte;
		r.ack_missing = nak_flag;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (scl_out !== want.scl_out) begin
					$error("scl_out: expected %0d, got %0d", want.scl_out, scl_out);
					mismatch_count++;
				end
				if (sda_out !== want.sda_out) begin
					$error("sda_out: expected %0d, got %0d", want.sda_out, sda_out);
					mismatch_count++;
				end
				if (busy_res !== want.busy_res) begin
					$error("busy_res: expected %0d, got %0d", want.busy_res, busy_res);
					mismatch_count++;
				end
				if (done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d", want.done_res, done_res);
					mismatch_count++;
				end
				if (read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data, read_data);
					mismatch_count++;
				end
				if (ack_missing !== want.ack_missing) begin
					$error("ack_missing: expected %0d, got %0d", want.ack_missing,
						ack_missing);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 36);
			end
		end
	end

	task automatic send_word(input item_t w);
		while (idle_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd_valid <= w.cmd_valid;
		action <= w.action;
		write_data <= w.write_data;
		sda_in <= w.sda_in;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(tick_sequencer(w));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic [PHASE_W-1:0] ticks,
			input logic [TIMEOUT_W-1:0] limit);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= CFG_DATA_W'(limit);
		@(posedge clk);
		cfg_we <= 1'b0;
		phase_cfg = ticks;
		timeout_cfg = limit;
	endtask

	function automatic item_t next_tick();
		item_t w;
		w.write_data = 8'($urandom_range(255));
		w.action = 3'($urandom_range(7));
		if (seq_ph == SEQ_IDLE)
			w.cmd_valid = ($urandom_range(3) != 0);
		else
			w.cmd_valid = ($urandom_range(7) == 0);
		if (seq_ph == SEQ_IDLE && w.cmd_valid && w.action == ACT_WAIT)
			never_ack = ($urandom_range(3) == 0);
		if (cur_act == ACT_WAIT && seq_ph != SEQ_IDLE)
			w.sda_in = never_ack ? 1'b1 : ($urandom_range(3) != 0);
		else
			w.sda_in = 1'($urandom_range(1));
		return w;
	endfunction

	task automatic run_ticks(input int n);
		repeat (n) send_word(next_tick());
	endtask

	// offer the command once, then keep offering ignored start commands until idle
	task automatic issue(input logic [ACT_W-1:0] act, input logic [7:0] data,
			input logic sda);
		item_t w;
		w.cmd_valid = 1'b1;
		w.action = act;
		w.write_data = data;
		w.sda_in = sda;
		send_word(w);
		w.action = ACT_START;
		while (seq_ph != SEQ_IDLE)
			send_word(w);
	endtask

	task automatic test_reset_config();
		run_ticks(30);
	endtask

	task automatic test_directed();
		item_t w;
		configure(16'd0, 10'd0);
		w.cmd_valid = 1'b1;
		w.action = ACT_UNUSED;
		w.write_data = 8'h00;
		w.sda_in = 1'b0;
		send_word(w);
		issue(ACT_START, 8'h00, 1'b1);
		issue(ACT_WRITE, 8'hFF, 1'b0);
		issue(ACT_WAIT, 8'h00, 1'b1);
		issue(ACT_WAIT, 8'h00, 1'b0);
		issue(ACT_READ, 8'h00, 1'b1);
		issue(ACT_ACK, 8'h00, 1'b1);
		issue(ACT_NACK, 8'h00, 1'b0);
		issue(ACT_STOP, 8'h00, 1'b1);
	endtask

	task automatic test_random_settings();
		configure(16'd1, 10'd2);
		run_ticks(200);
		configure(16'd2, 10'd7);
		run_ticks(200);
		configure(16'd3, 10'd1);
		run_ticks(150);
		configure(16'd1, 10'd1023);
		run_ticks(200);
		configure(16'd0, 10'd0);
		run_ticks(100);
		configure(16'd65535, 10'd1);
		run_ticks(40);
	endtask

	task automatic test_no_idling();
		idle_on = 1'b0;
		configure(16'd1, 10'd4);
		run_ticks(250);
		idle_on = 1'b1;
	endtask

	task automatic test_output_hold();
		idle_on = 1'b0;
		hold_req = 1'b1;
		run_ticks(40);
		idle_on = 1'b1;
	endtask

	task automatic test_input_pause();
		drain();
		run_ticks(60);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd_valid <= 1'b0;
		action <= ACT_START;
		write_data <= 8'h00;
		sda_in <= 1'b1;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data <= '0;
		mismatch_count = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		never_ack = 1'b0;
		phase_cfg = PHASE_TICKS_RST;
		timeout_cfg = ACK_TIMEOUT_RST;
		seq_ph = SEQ_IDLE;
		cur_act = ACT_START;
		shifter = 8'd0;
		dwell = '0;
		poll_count = '0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		nak_flag = 1'b0;
		rd_byte = 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_config();
		test_directed();
		test_random_settings();
		test_no_idling();
		test_output_hold();
		test_input_pause();
		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
